// ===== hdl/lfps_pkg.sv =====
// shared types, widths and codes of the lathe feed pass sequencer
`default_nettype none

package lfps_pkg;

	localparam int POS_W      = 32;
	localparam int SPEED_W    = 23;
	localparam int MOTION_W   = 3;
	localparam int STEP_W     = 3;
	localparam int PASS_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// motion command codes
	localparam logic [MOTION_W-1:0] MV_NONE  = 3'd0;
	localparam logic [MOTION_W-1:0] MV_STOP  = 3'd1;
	localparam logic [MOTION_W-1:0] MV_LEFT  = 3'd2;
	localparam logic [MOTION_W-1:0] MV_RIGHT = 3'd3;
	localparam logic [MOTION_W-1:0] MV_UP    = 3'd4;
	localparam logic [MOTION_W-1:0] MV_DOWN  = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FEED_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_TOTAL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FEED_PER_REV   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPINDLE_SPEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAVERSE_SPEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_DEPTH     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRACT_OFFSET = 3'd6;

	// mm/min to hundredths of mm/min
	localparam logic [SPEED_W-1:0] RAPID_SCALE = 23'd100;

	typedef enum logic [STEP_W-1:0] {
		STEP_START       = 3'd0,
		STEP_FEED_BEGIN  = 3'd1,
		STEP_FEED        = 3'd2,
		STEP_RETRACT     = 3'd3,
		STEP_RETURN      = 3'd4,
		STEP_INFEED      = 3'd5,
		STEP_REENTER     = 3'd6,
		STEP_COUNT       = 3'd7
	} step_t;

	typedef struct packed {
		logic [1:0]  feed_mode;
		logic [7:0]  pass_total;
		logic [9:0]  feed_per_rev;
		logic [12:0] spindle_speed;
		logic [15:0] traverse_speed;
		logic [15:0] pass_depth;
		logic [15:0] retract_offset;
	} cfg_t;

	typedef struct packed {
		logic             kind;
		logic             at_left_limit;
		logic             at_right_limit;
		logic             at_up_limit;
		logic             at_down_limit;
		logic             left_limit_defined;
		logic             right_limit_defined;
		logic [POS_W-1:0] cross_position;
	} in_item_t;

	typedef struct packed {
		logic [MOTION_W-1:0] motion;
		logic [SPEED_W-1:0]  speed;
		logic [STEP_W-1:0]   step_now;
		logic [PASS_W-1:0]   passes_finished;
		logic                job_complete;
		logic                error_no_limits;
		logic                error_not_at_start;
		logic                display_update;
		logic [POS_W-1:0]    up_limit_position;
		logic [POS_W-1:0]    down_limit_position;
		logic                up_limit_armed;
		logic                down_limit_armed;
	} out_item_t;

	typedef struct packed {
		step_t            step;
		logic [PASS_W-1:0] pass_count;
		logic [POS_W-1:0] up_pos;
		logic [POS_W-1:0] down_pos;
		logic             up_armed;
		logic             down_armed;
	} seq_state_t;

endpackage

`default_nettype wire

// ===== hdl/lfps_ifs.sv =====
// channel interfaces: tick items, result items and configuration writes
`default_nettype none

interface lfps_item_if;
	import lfps_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic             at_left_limit;
	logic             at_right_limit;
	logic             at_up_limit;
	logic             at_down_limit;
	logic             left_limit_defined;
	logic             right_limit_defined;
	logic [POS_W-1:0] cross_position;

	modport source (output valid, kind, at_left_limit, at_right_limit, at_up_limit,
		at_down_limit, left_limit_defined, right_limit_defined, cross_position,
		input ready);
	modport sink (input valid, kind, at_left_limit, at_right_limit, at_up_limit,
		at_down_limit, left_limit_defined, right_limit_defined, cross_position,
		output ready);
endinterface

interface lfps_result_if;
	import lfps_pkg::*;

	logic                valid;
	logic                ready;
	logic [MOTION_W-1:0] motion;
	logic [SPEED_W-1:0]  speed;
	logic [STEP_W-1:0]   step_now;
	logic [PASS_W-1:0]   passes_finished;
	logic                job_complete;
	logic                error_no_limits;
	logic                error_not_at_start;
	logic                display_update;
	logic [POS_W-1:0]    up_limit_position;
	logic [POS_W-1:0]    down_limit_position;
	logic                up_limit_armed;
	logic                down_limit_armed;

	modport source (output valid, motion, speed, step_now, passes_finished, job_complete,
		error_no_limits, error_not_at_start, display_update, up_limit_position,
		down_limit_position, up_limit_armed, down_limit_armed, input ready);
	modport sink (input valid, motion, speed, step_now, passes_finished, job_complete,
		error_no_limits, error_not_at_start, display_update, up_limit_position,
		down_limit_position, up_limit_armed, down_limit_armed, output ready);
endinterface

interface lfps_cfg_if;
	import lfps_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/lfps_cfg_regs.sv =====
// configuration register file
`default_nettype none

module lfps_cfg_regs (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lfps_cfg_if.sink      cfg,
	output lfps_pkg::cfg_t regs
);
	import lfps_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.feed_mode      <= 2'd0;
			regs_q.pass_total     <= 8'd1;
			regs_q.feed_per_rev   <= 10'd10;
			regs_q.spindle_speed  <= 13'd0;
			regs_q.traverse_speed <= 16'd0;
			regs_q.pass_depth     <= 16'd0;
			regs_q.retract_offset <= 16'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FEED_MODE:      regs_q.feed_mode      <= cfg.data[1:0];
				CFG_PASS_TOTAL:     regs_q.pass_total     <= cfg.data[7:0];
				CFG_FEED_PER_REV:   regs_q.feed_per_rev   <= cfg.data[9:0];
				CFG_SPINDLE_SPEED:  regs_q.spindle_speed  <= cfg.data[12:0];
				CFG_TRAVERSE_SPEED: regs_q.traverse_speed <= cfg.data;
				CFG_PASS_DEPTH:     regs_q.pass_depth     <= cfg.data;
				CFG_RETRACT_OFFSET: regs_q.retract_offset <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lfps_step_logic.sv =====
// one sequencer step: next state and result item for one tick or reset item
`default_nettype none

module lfps_step_logic (
	input  wire lfps_pkg::cfg_t       cfg,
	input  wire lfps_pkg::in_item_t   it,
	input  wire lfps_pkg::seq_state_t cur,
	output lfps_pkg::seq_state_t nxt,
	output lfps_pkg::out_item_t  res
);
	import lfps_pkg::*;

	logic               internal_cut;
	logic               feed_left;
	logic               at_start;
	logic               at_end;
	logic               both_defined;
	logic               retracted;
	logic               reentered;
	logic [MOTION_W-1:0] feed_dir;
	logic [MOTION_W-1:0] back_dir;
	logic [SPEED_W-1:0] feed_speed;
	logic [SPEED_W-1:0] rapid_speed;
	logic               count_run;
	logic [PASS_W-1:0]  pass_next;
	logic               count_done;

	assign internal_cut = cfg.feed_mode[1];
	assign feed_left    = !cfg.feed_mode[0];
	assign at_start     = feed_left ? it.at_right_limit : it.at_left_limit;
	assign at_end       = feed_left ? it.at_left_limit : it.at_right_limit;
	assign both_defined = it.left_limit_defined && it.right_limit_defined;
	assign retracted    = internal_cut ? it.at_up_limit : it.at_down_limit;
	assign reentered    = internal_cut ? it.at_down_limit : it.at_up_limit;
	assign feed_dir     = feed_left ? MV_LEFT : MV_RIGHT;
	assign back_dir     = feed_left ? MV_RIGHT : MV_LEFT;

	// 10x13 and 16x7 products, both fit 23 bits
	assign feed_speed  = {13'd0, cfg.feed_per_rev} * {10'd0, cfg.spindle_speed};
	assign rapid_speed = {7'd0, cfg.traverse_speed} * RAPID_SCALE;

	// pass count saturates at the total
	assign count_run  = it.kind &&
		((cur.step == STEP_RETURN && at_start) || cur.step == STEP_COUNT);
	assign pass_next  = (cur.pass_count < cfg.pass_total) ? cur.pass_count + 8'd1
		: cur.pass_count;
	assign count_done = pass_next >= cfg.pass_total;

	// next state
	always_comb begin
		nxt = cur;
		if (!it.kind) begin
			nxt.step       = STEP_START;
			nxt.pass_count = '0;
		end else if (count_run) begin
			nxt.pass_count = pass_next;
			nxt.step       = count_done ? STEP_COUNT : STEP_INFEED;
		end else begin
			case (cur.step)
				STEP_START: begin
					if (at_start && both_defined) begin
						nxt.step = STEP_FEED_BEGIN;
						if (internal_cut) begin
							nxt.down_pos   = it.cross_position;
							nxt.down_armed = 1'b1;
						end else begin
							nxt.up_pos   = it.cross_position;
							nxt.up_armed = 1'b1;
						end
					end
				end
				STEP_FEED_BEGIN: nxt.step = STEP_FEED;
				STEP_FEED: begin
					if (at_end) begin
						nxt.step = STEP_RETRACT;
						if (internal_cut) begin
							nxt.up_pos   = it.cross_position + {16'd0, cfg.retract_offset};
							nxt.up_armed = 1'b1;
						end else begin
							nxt.down_pos   = it.cross_position - {16'd0, cfg.retract_offset};
							nxt.down_armed = 1'b1;
						end
					end
				end
				STEP_RETRACT: begin
					if (retracted) begin
						nxt.step = STEP_RETURN;
					end
				end
				STEP_INFEED: begin
					nxt.step = STEP_REENTER;
					if (internal_cut) begin
						nxt.down_pos = cur.down_pos - {16'd0, cfg.pass_depth};
					end else begin
						nxt.up_pos = cur.up_pos + {16'd0, cfg.pass_depth};
					end
				end
				STEP_REENTER: begin
					if (reentered) begin
						nxt.step = STEP_FEED_BEGIN;
					end
				end
				default: ;
			endcase
		end
	end

	// result item
	always_comb begin
		res = '0;
		if (it.kind) begin
			if (count_run) begin
				res.job_complete   = count_done;
				res.display_update = 1'b1;
			end else begin
				case (cur.step)
					STEP_START: begin
						res.motion = MV_STOP;
						if (!(at_start && both_defined)) begin
							res.display_update     = 1'b1;
							res.error_no_limits    = !both_defined;
							res.error_not_at_start = both_defined;
						end
					end
					STEP_FEED_BEGIN: begin
						res.motion = feed_dir;
						res.speed  = feed_speed;
					end
					STEP_FEED: begin
						if (at_end) begin
							res.motion = internal_cut ? MV_UP : MV_DOWN;
							res.speed  = rapid_speed;
						end else begin
							res.motion = feed_dir;
							res.speed  = feed_speed;
						end
					end
					STEP_RETRACT: begin
						if (retracted) begin
							res.motion = back_dir;
							res.speed  = rapid_speed;
						end
					end
					STEP_INFEED: begin
						res.motion = internal_cut ? MV_DOWN : MV_UP;
						res.speed  = rapid_speed;
					end
					default: ;
				endcase
			end
		end
		res.step_now            = nxt.step;
		res.passes_finished     = nxt.pass_count;
		res.up_limit_position   = nxt.up_pos;
		res.down_limit_position = nxt.down_pos;
		res.up_limit_armed      = nxt.up_armed;
		res.down_limit_armed    = nxt.down_armed;
	end

endmodule

`default_nettype wire

// ===== hdl/lathe_feed_pass_sequencer_unit.sv =====
// top level of the lathe multi-pass power-feed sequencer
`default_nettype none

// Multi-pass power-feed sequencer for a lathe. Each item on the item channel is
// either a sequence reset (kind 0) or one sequencer tick (kind 1) carrying the
// limit switch flags and the cross slide position; each item gives exactly one
// result item with the motion command, its speed in 0.01 mm/min, the step and
// pass count after the item, error and display flags and the limit state.
// Rate: one item per clock cycle sustained while results are taken at once.
// The item enters an input register; once the result register is empty or
// being taken, one pass of the step logic (including the two speed
// multipliers) fills the result register and the sequencer state in the same
// edge, so the state loop holds only the state register. The item channel
// stays ready while the input register is empty or moving on, which it does
// whenever the result register is empty or being taken. Configuration writes
// are always accepted, but must only be issued while no item is in flight.
// Limit positions wrap modulo 2^32.

module lathe_feed_pass_sequencer_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lfps_item_if.sink   item,
	lfps_result_if.source result,
	lfps_cfg_if.sink    cfg
);
	import lfps_pkg::*;

	cfg_t       cfg_regs;
	in_item_t   item_in;
	in_item_t   item_s1;
	logic       valid_s1;
	seq_state_t state_q;
	seq_state_t state_next;
	out_item_t  res_next;
	out_item_t  result_q;
	logic       result_valid_q;
	logic       advance;

	// configuration registers
	lfps_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// gather the incoming transaction
	assign item_in.kind                = item.kind;
	assign item_in.at_left_limit       = item.at_left_limit;
	assign item_in.at_right_limit      = item.at_right_limit;
	assign item_in.at_up_limit         = item.at_up_limit;
	assign item_in.at_down_limit       = item.at_down_limit;
	assign item_in.left_limit_defined  = item.left_limit_defined;
	assign item_in.right_limit_defined = item.right_limit_defined;
	assign item_in.cross_position      = item.cross_position;

	// stage 1 moves on when the result register is free or being drained
	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item_in;
		end
	end

	// step logic for the item in stage 1
	lfps_step_logic u_step_logic (
		.cfg (cfg_regs),
		.it  (item_s1),
		.cur (state_q),
		.nxt (state_next),
		.res (res_next)
	);

	// sequencer state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_next;
		end
	end

	// result channel
	assign result.valid               = result_valid_q;
	assign result.motion              = result_q.motion;
	assign result.speed               = result_q.speed;
	assign result.step_now            = result_q.step_now;
	assign result.passes_finished     = result_q.passes_finished;
	assign result.job_complete        = result_q.job_complete;
	assign result.error_no_limits     = result_q.error_no_limits;
	assign result.error_not_at_start  = result_q.error_not_at_start;
	assign result.display_update      = result_q.display_update;
	assign result.up_limit_position   = result_q.up_limit_position;
	assign result.down_limit_position = result_q.down_limit_position;
	assign result.up_limit_armed      = result_q.up_limit_armed;
	assign result.down_limit_armed    = result_q.down_limit_armed;

	// state only moves when a transaction is processed
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("sequencer state changed without a transaction");

	// a sequence reset item clears step and pass count
	a_reset_item: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !item_s1.kind) |=>
		(state_q.step == STEP_START && state_q.pass_count == '0))
		else $error("reset item did not clear step and pass count");

	// the shown result always matches the committed state
	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.step_now == state_q.step &&
		result_q.passes_finished == state_q.pass_count &&
		result_q.up_limit_position == state_q.up_pos &&
		result_q.down_limit_position == state_q.down_pos))
		else $error("result register out of step with sequencer state");

	// job complete only ever leaves the machine in the final step
	a_done_step: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.job_complete) |-> result_q.step_now == STEP_COUNT)
		else $error("job complete reported outside the final step");

	// an empty result register never blocks the item channel
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> item.ready)
		else $error("item channel stalled with empty result register");

endmodule

`default_nettype wire
